### sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, off while reset is asserted.
`define SMF_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked check that also holds during reset.
`define SMF_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SMF_ASSERT_RST(lbl, clk, rst_n, prop)
`define SMF_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

### sv/smf_pkg.sv
// Shared constants and types of the sliding median filter.
package smf_pkg;
  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int DATA_W     = 8;
  localparam int WS_W       = 5;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);
  localparam logic [APB_AW-3:0] REG_WINDOW_SIZE = '0;

  typedef struct packed {
    logic             load;
    logic             rank_en;
    logic [IDX_W-1:0] step;
    logic [CNT_W-1:0] win_n;
  } cell_ctrl_t;
endpackage

### sv/sliding_median_filter_unit.sv
// Top level of the sliding median filter: cell chain, sequencer and output register.
// A word that completes a window of window_size samples yields one median word; the
// newest sample enters cell 0 of a 16-cell shift chain in the accept cycle, then a probe
// ring rotates through all cells while each cell counts its own rank, and then the
// mean of the middle rank(s) goes into the output register. A word that yields a result
// holds in_ready low until then; a word that yields none leaves the block idle. A result
// waiting in the output register does not block the next word; only a finished median
// with the register still full waits. window_size 0 acts as 1, above 16 as 16.
`include "assert_macros.svh"
module sliding_median_filter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [smf_pkg::DATA_W-1:0] in_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [smf_pkg::DATA_W-1:0] out_median_value,
  output logic                       out_last_result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [smf_pkg::APB_AW-1:0] paddr,
  input  logic [smf_pkg::APB_DW-1:0] pwdata,
  output logic [smf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import smf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RANK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              last_r, last_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] med_r, med_nxt;
  logic              olast_r, olast_nxt;

  logic [WS_W-1:0]   window_size;
  logic [CNT_W-1:0]  win_n;
  logic [CNT_W-1:0]  fill_inc;
  logic              in_acc;
  logic              produce;
  logic              can_emit;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] x_w    [MAX_WINDOW];
  logic [DATA_W-1:0] p_w    [MAX_WINDOW];
  logic [IDX_W-1:0]  rank_w [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] lo_hit, hi_hit;
  logic [IDX_W-1:0]  lo_rank, hi_rank;
  logic [DATA_W-1:0] lo_val, hi_val;
  logic [DATA_W:0]   mid_sum;

  smf_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  always_comb begin
    if (window_size == '0) begin
      win_n = CNT_W'(1);
    end else if ({1'b0, window_size} > (WS_W+1)'(MAX_WINDOW)) begin
      win_n = CNT_W'(MAX_WINDOW);
    end else begin
      win_n = CNT_W'(window_size);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fill_inc = (fill_r < CNT_W'(MAX_WINDOW)) ? fill_r + CNT_W'(1) : fill_r;
  assign produce  = (fill_inc >= win_n);
  assign can_emit = !ov_r || out_ready;

  assign ctrl.load    = in_acc;
  assign ctrl.rank_en = (state_r == S_RANK);
  assign ctrl.step    = step_r;
  assign ctrl.win_n   = win_n;

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
      smf_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .cell_idx   (IDX_W'(k)),
        .shift_in   ((k == 0) ? in_sample : x_w[(k == 0) ? 0 : k-1]),
        .probe_in   (p_w[(k == 0) ? MAX_WINDOW-1 : k-1]),
        .sample_out (x_w[k]),
        .probe_out  (p_w[k]),
        .rank_out   (rank_w[k])
      );
      assign lo_hit[k] = (CNT_W'(k) < win_n) && (rank_w[k] == lo_rank);
      assign hi_hit[k] = (CNT_W'(k) < win_n) && (rank_w[k] == hi_rank);
    end
  endgenerate

  assign lo_rank = IDX_W'((win_n - CNT_W'(1)) >> 1);
  assign hi_rank = IDX_W'(win_n >> 1);

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_val = lo_val | ({DATA_W{lo_hit[i]}} & x_w[i]);
      hi_val = hi_val | ({DATA_W{hi_hit[i]}} & x_w[i]);
    end
  end

  assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r;
    med_nxt   = med_r;
    olast_nxt = olast_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fill_nxt = in_last_sample ? '0 : fill_inc;
          last_nxt = in_last_sample;
          step_nxt = '0;
          if (produce) begin
            state_nxt = S_RANK;
          end
        end
      end
      S_RANK: begin
        step_nxt = step_r + IDX_W'(1);
        if (step_r == IDX_W'(MAX_WINDOW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          med_nxt   = mid_sum[DATA_W:1];
          olast_nxt = last_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    med_r   <= med_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_median_value = med_r;
  assign out_last_result  = olast_r;

  `SMF_ASSERT_RST(a_rank_to_done, clk, rst_n,
    (state_r == S_RANK && step_r == IDX_W'(MAX_WINDOW - 1)) |=> (state_r == S_DONE))
  `SMF_ASSERT_RST(a_ranks_unique, clk, rst_n,
    (state_r == S_DONE) |-> ($onehot(lo_hit) && $onehot(hi_hit)))
  `SMF_ASSERT_RST(a_fill_bound, clk, rst_n, fill_r <= CNT_W'(MAX_WINDOW))
  `SMF_ASSERT_ALL(a_reset_idle, clk, !rst_n |=> (!out_valid && in_ready))
endmodule

### sv/smf_cell.sv
// One window cell: holds a sample, a rotating probe and the sample's rank.
module smf_cell (
  input  logic                      clk,
  input  smf_pkg::cell_ctrl_t       ctrl,
  input  logic [smf_pkg::IDX_W-1:0] cell_idx,
  input  logic [smf_pkg::DATA_W-1:0] shift_in,
  input  logic [smf_pkg::DATA_W-1:0] probe_in,
  output logic [smf_pkg::DATA_W-1:0] sample_out,
  output logic [smf_pkg::DATA_W-1:0] probe_out,
  output logic [smf_pkg::IDX_W-1:0]  rank_out
);
  import smf_pkg::*;

  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] p_r, p_nxt;
  logic [IDX_W-1:0]  rank_r, rank_nxt;
  logic [IDX_W-1:0]  src_idx;
  logic              hit;

  // probe currently holds the sample of cell (cell_idx - step)
  assign src_idx = cell_idx - ctrl.step;
  assign hit = ({1'b0, src_idx} < ctrl.win_n) &&
               ((p_r < x_r) || ((p_r == x_r) && (src_idx < cell_idx)));

  always_comb begin
    x_nxt    = x_r;
    p_nxt    = p_r;
    rank_nxt = rank_r;
    if (ctrl.load) begin
      x_nxt    = shift_in;
      p_nxt    = shift_in;
      rank_nxt = '0;
    end else if (ctrl.rank_en) begin
      p_nxt    = probe_in;
      rank_nxt = rank_r + IDX_W'(hit);
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    p_r    <= p_nxt;
    rank_r <= rank_nxt;
  end

  assign sample_out = x_r;
  assign probe_out  = p_r;
  assign rank_out   = rank_r;
endmodule

### sv/smf_apb.sv
// APB register block holding the window size.
module smf_apb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [smf_pkg::APB_AW-1:0] paddr,
  input  logic [smf_pkg::APB_DW-1:0] pwdata,
  output logic [smf_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [smf_pkg::WS_W-1:0]   window_size
);
  import smf_pkg::*;

  logic [WS_W-1:0] ws_r, ws_nxt;
  logic            wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_WINDOW_SIZE);

  always_comb begin
    ws_nxt = ws_r;
    if (wr_hit) begin
      ws_nxt = pwdata[WS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else begin
      ws_r <= ws_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_WINDOW_SIZE) begin
      prdata = {{(APB_DW-WS_W){1'b0}}, ws_r};
    end
  end

  assign window_size = ws_r;
endmodule

### verif/sliding_median_filter_unit_tb.sv
// Self-checking testbench for sliding_median_filter_unit: directed cases, then random runs.
module sliding_median_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [smf_pkg::DATA_W-1:0] median;
    logic                       is_last;
  } median_word_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [smf_pkg::DATA_W-1:0]   in_sample = '0;
  logic                         in_last_sample = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [smf_pkg::DATA_W-1:0]   out_median_value;
  logic                         out_last_result;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [smf_pkg::APB_AW-1:0]   paddr = '0;
  logic [smf_pkg::APB_DW-1:0]   pwdata = '0;
  logic [smf_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // predictor state
  logic [smf_pkg::DATA_W-1:0]   sample_ring [smf_pkg::MAX_WINDOW];
  logic [smf_pkg::IDX_W-1:0]    ring_pos = '0;
  int unsigned                  run_fill = 0;
  logic [smf_pkg::WS_W-1:0]     window_size_q = smf_pkg::WS_RESET;

  median_word_t                 pending_medians [$];
  int unsigned                  mismatch_count = 0;
  int unsigned                  snd_idle_pct = 0;
  int unsigned                  rcv_stall_pct = 0;

  sliding_median_filter_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median_value (out_median_value),
    .out_last_result  (out_last_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned effective_size(logic [smf_pkg::WS_W-1:0] ws);
    if (ws == 0) begin
      return 1;
    end
    if (ws > smf_pkg::MAX_WINDOW) begin
      return smf_pkg::MAX_WINDOW;
    end
    return ws;
  endfunction

  function automatic logic [smf_pkg::DATA_W-1:0] median_of_window(int unsigned n);
    logic [smf_pkg::DATA_W-1:0] vals [smf_pkg::MAX_WINDOW];
    logic [smf_pkg::DATA_W-1:0] v;
    logic [smf_pkg::IDX_W-1:0]  pos;
    logic [smf_pkg::DATA_W:0]   total;
    int unsigned                k;
    int unsigned                m;
    pos = ring_pos;
    for (k = 0; k < n; k++) begin
      pos = pos - smf_pkg::IDX_W'(1);
      vals[k] = sample_ring[pos];
    end
    for (k = 1; k < n; k++) begin
      v = vals[k];
      m = k;
      while (m > 0 && vals[m-1] > v) begin
        vals[m] = vals[m-1];
        m--;
      end
      vals[m] = v;
    end
    if (n % 2 == 1) begin
      return vals[n/2];
    end
    total = vals[n/2] + vals[n/2-1];
    return total[smf_pkg::DATA_W:1];
  endfunction

  task automatic model_accept(input logic [smf_pkg::DATA_W-1:0] smp, input logic is_last);
    int unsigned  n;
    median_word_t w;
    n = effective_size(window_size_q);
    sample_ring[ring_pos] = smp;
    ring_pos = ring_pos + smf_pkg::IDX_W'(1);
    if (run_fill < smf_pkg::MAX_WINDOW) begin
      run_fill++;
    end
    if (run_fill >= n) begin
      w.median = median_of_window(n);
      w.is_last = is_last;
      pending_medians.push_back(w);
    end
    if (is_last) begin
      run_fill = 0;
    end
  endtask

  task automatic send_word(input logic [smf_pkg::DATA_W-1:0] smp, input logic is_last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_last_sample <= is_last;
    do @(posedge clk); while (!in_ready);
    model_accept(smp, is_last);
  endtask

  // drain: no word in flight, then let the last non-producing word settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [smf_pkg::APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {smf_pkg::REG_WINDOW_SIZE, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_size_q = value[smf_pkg::WS_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== smf_pkg::APB_DW'(window_size_q)) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("window_size readback: expected %0d got %0d", window_size_q, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    median_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_medians.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected median word: median %0d last %0b",
                   out_median_value, out_last_result);
        end
      end else begin
        want = pending_medians.pop_front();
        if (out_median_value !== want.median || out_last_result !== want.is_last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("median word: expected median %0d last %0b, got median %0d last %0b",
                     want.median, want.is_last, out_median_value, out_last_result);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic test_reset_window();
    send_word(8'd200, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b1);
    // run shorter than the window: no word, fill count still clears
    send_word(8'd9, 1'b1);
    wait_idle();
  endtask

  task automatic test_size_extremes();
    write_window_size(32'd1);
    send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b1);
    wait_idle();
    write_window_size(32'd0);
    send_word(8'd1, 1'b1);
    wait_idle();
    write_window_size(32'd2);
    send_word(8'd255, 1'b0);
    send_word(8'd254, 1'b1);
    wait_idle();
  endtask

  task automatic test_mid_run_resize();
    int unsigned i;
    write_window_size(32'd17);
    for (i = 0; i < 15; i++) begin
      send_word(8'(255 - 17 * i), 1'b0);
    end
    wait_idle();
    write_window_size(32'd2);
    send_word(8'd100, 1'b0);
    wait_idle();
    write_window_size(32'd31);
    send_word(8'd1, 1'b1);
    wait_idle();
  endtask

  function automatic logic [smf_pkg::DATA_W-1:0] pick_sample(int unsigned style,
                                                             int unsigned idx,
                                                             logic [7:0] base);
    case (style)
      0: return 8'($urandom_range(255));
      1: return base + 8'($urandom_range(3));
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return base + 8'(idx * 37);
    endcase
  endfunction

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    int unsigned eff;
    int unsigned len;
    int unsigned style;
    int unsigned i;
    logic        closed;
    logic [7:0]  base;
    logic [smf_pkg::APB_DW-1:0] value;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      value = $urandom;
      if ($urandom_range(99) < 10) begin
        value[smf_pkg::WS_W-1:0] = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
      end else begin
        value[smf_pkg::WS_W-1:0] = 5'($urandom_range(1, smf_pkg::MAX_WINDOW));
      end
      write_window_size(value);
      eff = effective_size(window_size_q);
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(99);
        closed = 1'b1;
        if (r < 70) begin
          len = $urandom_range(eff, eff + 20);
        end else if (r < 85) begin
          len = $urandom_range(1, eff);
        end else begin
          len = $urandom_range(1, 30);
          closed = 1'b0;
        end
        style = $urandom_range(3);
        base = 8'($urandom_range(255));
        for (i = 0; i < len; i++) begin
          send_word(pick_sample(style, i, base), closed && (i == len - 1));
        end
        sent += len;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_size_extremes();
    test_mid_run_resize();
    test_random_traffic(6, 80, 500);
    test_random_traffic(80, 6, 500);
    test_random_traffic(0, 0, 500);
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("sliding_median_filter_unit regression: pass");
    end else begin
      $display("sliding_median_filter_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("sliding_median_filter_unit regression: fail");
    $finish;
  end
endmodule

### sliding_median_filter_unit.f
+incdir+sv
sv/smf_pkg.sv
sv/smf_cell.sv
sv/smf_apb.sv
sv/sliding_median_filter_unit.sv
verif/sliding_median_filter_unit_tb.sv
